// File: design/bba_pkg.sv
package bba_pkg;

  // fixed field widths of the transaction payloads
  localparam int FIELD_W        = 48;
  localparam int COUNT_W        = 32;
  localparam int OP_W           = 2;
  localparam int BYTE_WIDTH_DEF = 48;

  // request operation codes
  typedef enum logic [OP_W-1:0] {
    OP_ACQUIRE = 2'd0,
    OP_RELEASE = 2'd1,
    OP_SHRINK  = 2'd2
  } op_t;

  // one request as held in the input register
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] amount;
    logic [FIELD_W-1:0] shrink_to;
  } req_t;

  // input register towards the budget core
  typedef struct packed {
    logic valid;
    req_t req;
  } stage_t;

  // one result as held in the output register
  typedef struct packed {
    logic               granted;
    logic               error;
    logic [FIELD_W-1:0] in_use;
    logic [FIELD_W-1:0] peak_use;
    logic [COUNT_W-1:0] reject_count;
  } rsp_t;

endpackage

// File: design/bba_if.sv
// request channel
interface bba_in_if;
  import bba_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [FIELD_W-1:0] amount;
  logic [FIELD_W-1:0] shrink_to;

  modport source (output valid, output op, output amount, output shrink_to, input ready);
  modport sink   (input valid, input op, input amount, input shrink_to, output ready);
endinterface

// result channel
interface bba_out_if;
  import bba_pkg::*;

  logic               valid;
  logic               ready;
  logic               granted;
  logic               error;
  logic [FIELD_W-1:0] in_use;
  logic [FIELD_W-1:0] peak_use;
  logic [COUNT_W-1:0] reject_count;

  modport source (output valid, output granted, output error, output in_use,
                  output peak_use, output reject_count, input ready);
  modport sink   (input valid, input granted, input error, input in_use,
                  input peak_use, input reject_count, output ready);
endinterface

// File: design/byte_budget_admission_top.sv
// channel  | direction | handshake         | payload
// in_ch    | in        | valid / ready     | op, amount, shrink_to
// out_ch   | out       | valid / ready     | granted, error, in_use, peak_use, reject_count
// cfg      | in        | cfg_we            | cfg_wdata (capacity)
//
// one transaction per cycle sustained while out_ch is ready; a result is offered once
// the transaction has passed the input register and then the result register
// the budget state closes its loop combinationally: compare, add or subtract, saturate
// synchronous active-low reset clears capacity, use, peak, reject count and valids
// a stalled result holds while the input register still takes one more transaction
module byte_budget_admission_top #(
  parameter int BYTE_WIDTH = bba_pkg::BYTE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bba_pkg::FIELD_W-1:0] cfg_wdata,
  bba_in_if.sink                      in_ch,
  bba_out_if.source                   out_ch
);
  import bba_pkg::*;

  stage_t stage;
  logic   advance;

  // input register
  bba_in_stage u_in_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .advance (advance),
    .stage   (stage)
  );

  // budget state and result register
  bba_core #(
    .BYTE_WIDTH (BYTE_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stage     (stage),
    .advance   (advance),
    .out_ch    (out_ch)
  );

endmodule

// File: design/bba_in_stage.sv
module bba_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  bba_in_if.sink          in_ch,
  input  logic            advance,
  output bba_pkg::stage_t stage
);
  import bba_pkg::*;

  logic valid_r;
  logic valid_nxt;
  req_t req_r;
  logic accept;

  // register frees up whenever its contents move on
  assign in_ch.ready = !valid_r || advance;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload capture, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.op        <= in_ch.op;
      req_r.amount    <= in_ch.amount;
      req_r.shrink_to <= in_ch.shrink_to;
    end
  end

  assign stage.valid = valid_r;
  assign stage.req   = req_r;

endmodule

// File: design/bba_core.sv
module bba_core #(
  parameter int BYTE_WIDTH = bba_pkg::BYTE_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [bba_pkg::FIELD_W-1:0] cfg_wdata,
  input  bba_pkg::stage_t             stage,
  output logic                        advance,
  bba_out_if.source                   out_ch
);
  import bba_pkg::*;

  // common width for moving between field and budget widths
  localparam int XW = (BYTE_WIDTH > FIELD_W) ? BYTE_WIDTH : FIELD_W;

  logic [BYTE_WIDTH-1:0] cap_r;
  logic [BYTE_WIDTH-1:0] used_r;
  logic [BYTE_WIDTH-1:0] used_nxt;
  logic [BYTE_WIDTH-1:0] peak_r;
  logic [BYTE_WIDTH-1:0] peak_nxt;
  logic [COUNT_W-1:0]    rej_r;
  logic [COUNT_W-1:0]    rej_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  rsp_t                  rsp_r;
  rsp_t                  rsp_nxt;

  logic [XW-1:0]         cfg_wide;
  logic [XW-1:0]         amt_wide;
  logic [XW-1:0]         tgt_wide;
  logic [XW-1:0]         used_out_wide;
  logic [XW-1:0]         peak_out_wide;
  logic [BYTE_WIDTH-1:0] amt;
  logic [BYTE_WIDTH-1:0] tgt;
  logic [BYTE_WIDTH-1:0] held;
  logic [BYTE_WIDTH-1:0] room;
  logic [BYTE_WIDTH-1:0] diff;
  logic                  granted;
  logic                  error;

  // fit the 48-bit fields to the budget width
  assign cfg_wide = XW'(cfg_wdata);
  assign amt_wide = XW'(stage.req.amount);
  assign tgt_wide = XW'(stage.req.shrink_to);
  assign amt      = amt_wide[BYTE_WIDTH-1:0];
  assign tgt      = tgt_wide[BYTE_WIDTH-1:0];

  // free space and shrink difference
  assign held = (used_r < cap_r) ? used_r : cap_r;
  assign room = cap_r - held;
  assign diff = amt - tgt;

  // budget update for the transaction in the input register
  always_comb begin
    used_nxt = used_r;
    peak_nxt = peak_r;
    rej_nxt  = rej_r;
    granted  = 1'b0;
    error    = 1'b0;
    unique case (op_t'(stage.req.op))
      OP_ACQUIRE: begin
        if (amt > room) begin
          if (rej_r != '1) begin
            rej_nxt = rej_r + COUNT_W'(1);
          end
        end else begin
          used_nxt = used_r + amt;
          granted  = 1'b1;
          if (used_nxt > peak_r) begin
            peak_nxt = used_nxt;
          end
        end
      end
      OP_RELEASE: begin
        used_nxt = (amt > used_r) ? '0 : used_r - amt;
      end
      OP_SHRINK: begin
        if ((tgt > amt) || (diff > used_r)) begin
          error = 1'b1;
        end else begin
          used_nxt = used_r - diff;
        end
      end
      default: begin
      end
    endcase
  end

  // result word back at field width
  assign used_out_wide = XW'(used_nxt);
  assign peak_out_wide = XW'(peak_nxt);

  always_comb begin
    rsp_nxt.granted      = granted;
    rsp_nxt.error        = error;
    rsp_nxt.in_use       = used_out_wide[FIELD_W-1:0];
    rsp_nxt.peak_use     = peak_out_wide[FIELD_W-1:0];
    rsp_nxt.reject_count = rej_nxt;
  end

  // move on when the output register is empty or being drained
  assign advance = stage.valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // budget state and capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= '0;
      used_r      <= '0;
      peak_r      <= '0;
      rej_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wide[BYTE_WIDTH-1:0];
      end
      if (advance) begin
        used_r <= used_nxt;
        peak_r <= peak_nxt;
        rej_r  <= rej_nxt;
      end
    end
  end

  // result register, no reset
  always_ff @(posedge clk) begin
    if (advance) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.granted      = rsp_r.granted;
  assign out_ch.error        = rsp_r.error;
  assign out_ch.in_use       = rsp_r.in_use;
  assign out_ch.peak_use     = rsp_r.peak_use;
  assign out_ch.reject_count = rsp_r.reject_count;

endmodule

// File: design/bba_checker.sv
module bba_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  bba_in_if.sink                      in_ch,
  bba_out_if.source                   out_ch
);
  import bba_pkg::*;

  // no result straight after reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("result valid after reset");

  // an empty output side always leaves room for a new transaction
  a_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled while output empty");

  // granted and error are exclusive
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.granted && out_ch.error))
    else $error("granted and error both set");

  // a granted acquire leaves peak at or above use
  a_peak_covers_use: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.granted |-> out_ch.peak_use >= out_ch.in_use)
    else $error("peak below use after grant");

  // a stalled result holds: valid, in_use and reject_count stay
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.in_use)
      && $stable(out_ch.reject_count))
    else $error("stalled result changed");

endmodule

bind byte_budget_admission_top bba_checker u_bba_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ch     (in_ch),
  .out_ch    (out_ch)
);

// File: tb/tb_byte_budget_admission_top.sv
module tb_byte_budget_admission_top;
  import bba_pkg::*;

  localparam logic [OP_W-1:0]    OP_UNUSED   = 2'd3;
  localparam logic [FIELD_W-1:0] BYTES_MAX   = {FIELD_W{1'b1}};
  localparam logic [COUNT_W-1:0] REJECTS_MAX = {COUNT_W{1'b1}};
  localparam int                 HOLD_CYCLES = 120;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [FIELD_W-1:0] cfg_wdata;

  bba_in_if  req_if ();
  bba_out_if rsp_if ();

  byte_budget_admission_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (req_if),
    .out_ch    (rsp_if)
  );

  // shadow of the budget state
  logic [FIELD_W-1:0] shadow_cap;
  logic [FIELD_W-1:0] shadow_used = '0;
  logic [FIELD_W-1:0] shadow_peak = '0;
  logic [COUNT_W-1:0] shadow_rejects = '0;

  req_t pending_reqs[$];
  rsp_t predicted_rsps[$];
  req_t offered_req;

  int sender_idle_pct;
  int receiver_stall_pct;
  logic pressure_armed;
  bit pressure_done = 1'b0;
  int hold_left = 0;
  int mismatches = 0;

  // coverage tallies for the summary
  int n_granted, n_refused, n_release, n_shrink, n_shrink_err, n_unused;
  int in_stall_cycles, n_results;

  // advance the shadow state by one request and return the result it gives
  function automatic rsp_t admit_request(req_t r);
    rsp_t res;
    logic [FIELD_W-1:0] held;
    logic [FIELD_W-1:0] room;
    res = '0;
    case (r.op)
      OP_ACQUIRE: begin
        held = (shadow_used < shadow_cap) ? shadow_used : shadow_cap;
        room = shadow_cap - held;
        if (r.amount > room) begin
          if (shadow_rejects != REJECTS_MAX) shadow_rejects = shadow_rejects + 1'b1;
          n_refused++;
        end else begin
          shadow_used = shadow_used + r.amount;
          if (shadow_used > shadow_peak) shadow_peak = shadow_used;
          res.granted = 1'b1;
          n_granted++;
        end
      end
      OP_RELEASE: begin
        shadow_used = (r.amount > shadow_used) ? '0 : shadow_used - r.amount;
        n_release++;
      end
      OP_SHRINK: begin
        n_shrink++;
        if (r.shrink_to > r.amount || (r.amount - r.shrink_to) > shadow_used) begin
          res.error = 1'b1;
          n_shrink_err++;
        end else begin
          shadow_used = shadow_used - (r.amount - r.shrink_to);
        end
      end
      default: n_unused++;
    endcase
    res.in_use       = shadow_used;
    res.peak_use     = shadow_peak;
    res.reject_count = shadow_rejects;
    return res;
  endfunction

  // uniform value in [0, bound]
  function automatic logic [FIELD_W-1:0] rand_upto(logic [FIELD_W-1:0] bound);
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    if (bound != BYTES_MAX) raw = raw % ({16'd0, bound} + 64'd1);
    return raw[FIELD_W-1:0];
  endfunction

  // byte count, mostly in proportion to the capacity
  function automatic logic [FIELD_W-1:0] pick_amount(logic [FIELD_W-1:0] scale);
    int sel;
    sel = $urandom_range(99);
    if (sel < 50) return rand_upto(scale >> $urandom_range(4));
    if (sel < 70) return rand_upto(scale);
    if (sel < 84) return rand_upto(BYTES_MAX);
    if (sel < 90) return '0;
    if (sel < 95) return BYTES_MAX;
    return scale;
  endfunction

  function automatic req_t make_req(logic [FIELD_W-1:0] cap);
    req_t r;
    logic [FIELD_W-1:0] scale;
    logic [FIELD_W-1:0] cut_max;
    int sel;
    scale = (cap < 16) ? 48'd16 : cap;
    sel = $urandom_range(99);
    r.amount = pick_amount(scale);
    r.shrink_to = rand_upto(BYTES_MAX);
    if (sel < 45) r.op = OP_ACQUIRE;
    else if (sel < 72) r.op = OP_RELEASE;
    else if (sel < 95) begin
      r.op = OP_SHRINK;
      // mostly a genuine shrink by a modest step, otherwise an arbitrary target
      if ($urandom_range(99) < 80) begin
        cut_max = (r.amount < (scale >> 2)) ? r.amount : (scale >> 2);
        r.shrink_to = r.amount - rand_upto(cut_max);
      end
    end else r.op = OP_UNUSED;
    return r;
  endfunction

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // request driver: offers the next pending request once the previous one is taken
  always @(posedge clk) begin
    bit fire;
    fire = (req_if.valid === 1'b1) && (req_if.ready === 1'b1);
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else begin
      if (req_if.valid === 1'b1 && req_if.ready !== 1'b1) in_stall_cycles++;
      if (fire) predicted_rsps.push_back(admit_request(offered_req));
      if (req_if.valid !== 1'b1 || fire) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          offered_req = pending_reqs.pop_front();
          req_if.valid     <= 1'b1;
          req_if.op        <= offered_req.op;
          req_if.amount    <= offered_req.amount;
          req_if.shrink_to <= offered_req.shrink_to;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: random stalls plus one long hold-off under pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else if (pressure_armed && !pressure_done) begin
      pressure_done = 1'b1;
      hold_left = HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // result monitor: compare each transaction with the oldest prediction
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      n_results++;
      if (predicted_rsps.size() == 0) begin
        $error("unexpected result transaction: in_use %0h", rsp_if.in_use);
        mismatches++;
      end else begin
        want = predicted_rsps.pop_front();
        if (rsp_if.granted !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, rsp_if.granted);
          mismatches++;
        end
        if (rsp_if.error !== want.error) begin
          $error("error: expected %0d, got %0d", want.error, rsp_if.error);
          mismatches++;
        end
        if (rsp_if.in_use !== want.in_use) begin
          $error("in_use: expected %0h, got %0h", want.in_use, rsp_if.in_use);
          mismatches++;
        end
        if (rsp_if.peak_use !== want.peak_use) begin
          $error("peak_use: expected %0h, got %0h", want.peak_use, rsp_if.peak_use);
          mismatches++;
        end
        if (rsp_if.reject_count !== want.reject_count) begin
          $error("reject_count: expected %0d, got %0d", want.reject_count,
                 rsp_if.reject_count);
          mismatches++;
        end
      end
    end
  end

  task automatic push_req(logic [OP_W-1:0] op, logic [FIELD_W-1:0] amount,
                          logic [FIELD_W-1:0] shrink_to);
    req_t r;
    r.op = op;
    r.amount = amount;
    r.shrink_to = shrink_to;
    pending_reqs.push_back(r);
  endtask

  // wait until every request has gone through and its result has come back
  // sampled away from the rising edge so the driver's updates have settled
  task automatic drain();
    while (pending_reqs.size() != 0 || req_if.valid === 1'b1 || predicted_rsps.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(logic [FIELD_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    shadow_cap = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int idle, int stall, logic [FIELD_W-1:0] cap, int count);
    drain();
    sender_idle_pct    <= idle;
    receiver_stall_pct <= stall;
    set_capacity(cap);
    repeat (count) pending_reqs.push_back(make_req(cap));
  endtask

  // stimulus
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    pressure_armed = 1'b0;
    shadow_cap = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // capacity from reset is zero: only a zero acquire fits
    push_req(OP_ACQUIRE, 48'd0, 48'd0);
    push_req(OP_ACQUIRE, 48'd1, 48'd0);
    push_req(OP_UNUSED, 48'd7, 48'd3);
    push_req(OP_RELEASE, 48'd0, 48'd0);
    push_req(OP_SHRINK, 48'd0, 48'd0);
    push_req(OP_SHRINK, 48'd5, 48'd3);
    push_req(OP_SHRINK, 48'd3, 48'd5);
    drain();

    // full capacity: extremes of the byte fields
    set_capacity(BYTES_MAX);
    push_req(OP_ACQUIRE, BYTES_MAX, 48'd0);
    push_req(OP_ACQUIRE, 48'd0, BYTES_MAX);
    push_req(OP_ACQUIRE, 48'd1, 48'd0);
    push_req(OP_SHRINK, BYTES_MAX, 48'd0);
    push_req(OP_SHRINK, BYTES_MAX, 48'd0);
    push_req(OP_ACQUIRE, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
    push_req(OP_RELEASE, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
    push_req(OP_RELEASE, BYTES_MAX, BYTES_MAX);
    push_req(OP_ACQUIRE, 48'h5555_5555_5555, 48'd0);
    push_req(OP_UNUSED, BYTES_MAX, BYTES_MAX);
    push_req(OP_RELEASE, BYTES_MAX, 48'd0);
    push_req(OP_ACQUIRE, 48'd1000, 48'd0);
    drain();

    // capacity lowered under the bytes already held
    set_capacity(48'd10);
    push_req(OP_ACQUIRE, 48'd0, 48'd0);
    push_req(OP_ACQUIRE, 48'd1, 48'd0);
    push_req(OP_SHRINK, 48'd100, 48'd40);
    push_req(OP_RELEASE, 48'd500, 48'd0);

    // random traffic over a range of capacities and pacing
    random_phase(0, 0, 48'd1000, 130);
    random_phase(61, 0, BYTES_MAX, 130);
    random_phase(0, 61, 48'd65535, 120);
    random_phase(31, 31, rand_upto(BYTES_MAX) >> $urandom_range(40), 120);

    // long receiver hold-off so the block fills and stalls its input
    random_phase(0, 0, 48'd5000, 100);
    pressure_armed <= 1'b1;

    random_phase(31, 31, 48'd1, 60);
    random_phase(61, 0, 48'd0, 40);
    drain();
    repeat (10) @(posedge clk);

    $display("results checked %0d: acquires granted %0d, refused %0d, releases %0d",
             n_results, n_granted, n_refused, n_release);
    $display("shrinks %0d (%0d invalid), unused op %0d, input stall cycles %0d",
             n_shrink, n_shrink_err, n_unused, in_stall_cycles);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: byte_budget_admission_top.f
design/bba_pkg.sv
design/bba_if.sv
design/bba_in_stage.sv
design/bba_core.sv
design/byte_budget_admission_top.sv
design/bba_checker.sv
tb/tb_byte_budget_admission_top.sv
